// ===== sv/tfdd_pkg.sv =====
package tfdd_pkg;

	localparam int TILE_COUNT = 1024;
	localparam int ADDR_W     = $clog2(TILE_COUNT);
	localparam int POS_W      = 12;
	localparam int TILE_W     = 8;

	localparam logic [POS_W-1:0]  POS_MAX    = 12'hFFF;
	localparam logic [POS_W-1:0]  TILE_LIMIT = POS_W'(TILE_COUNT);
	localparam logic [ADDR_W-1:0] FILL_LAST  = ADDR_W'(TILE_COUNT - 1);

	localparam logic [3:0] MODE_PLAIN     = 4'h0;
	localparam logic [3:0] MODE_PLAIN_PIX = 4'h3;
	localparam logic [3:0] MODE_DERIVE    = 4'h4;

	localparam logic [TILE_W-1:0] TILE_HIGH = 8'h80;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_READ = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_MODE  = 2'd1,
		ERR_RANGE = 2'd2
	} err_t;

	typedef enum logic [2:0] {
		PH_HEADER   = 3'd0,
		PH_COUNT8   = 3'd1,
		PH_COUNT_LO = 3'd2,
		PH_PATCH_HI = 3'd3,
		PH_PATCH_LO = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		ST_FILL = 2'd0,
		ST_IDLE = 2'd1,
		ST_READ = 2'd2
	} state_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] byte_value;
		logic [9:0] tile_index;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_value;
		logic       frame_done;
		logic [1:0] error_code;
	} out_item_t;

endpackage

// ===== sv/tfdd_if.sv =====
interface tfdd_in_if import tfdd_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tfdd_out_if import tfdd_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/tilemap_frame_delta_decoder.sv =====
// Order: a non-fill stream byte has its result registered in the result queue and offered
// the cycle after transfer; a read passes the ST_READ state and the registered RAM read before
// its result is queued; a fill header (modes 0 and 3) yields its result after the whole sweep.
// Throughput: one non-fill stream byte per cycle while idle with queue room; a read or fill
// holds off input until its result is queued, set by the single RAM port (registered read).
// Reset: asynchronous, active low; no item is taken until the clearing pass has zeroed the store.
module tilemap_frame_delta_decoder import tfdd_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	tfdd_in_if.sink     req,
	tfdd_out_if.source  rsp
);

	// Control state
	state_t              state_q, state_d;
	phase_t              phase_q, phase_d;
	logic [POS_W-1:0]    left_q, left_d;     // patches left in the frame
	logic [POS_W-1:0]    pos_q, pos_d;       // write position, saturating
	logic [7:0]          high_q, high_d;     // first byte of a patch word
	logic [3:0]          cnt_hi_q, cnt_hi_d; // derive-mode count high nibble
	logic [ADDR_W-1:0]   fill_cnt_q, fill_cnt_d;
	logic [3:0]          fill_val_q, fill_val_d;
	logic                fill_push_q, fill_push_d; // 0 for the post-reset clear
	logic                fill_done_q, fill_done_d; // frame_done of the fill result
	logic                rd_oob_q, rd_oob_d;

	// Store port
	logic [ADDR_W-1:0]   ram_addr;
	logic                ram_we;
	logic [TILE_W-1:0]   ram_wdata;
	logic [TILE_W-1:0]   ram_rdata;

	// Result queue: two entries, so a finished result can wait while the next item runs
	out_item_t           q_data_q [2];
	logic                q_wptr_q, q_rptr_q;
	logic [1:0]          q_cnt_q;
	logic                push, pop;
	out_item_t           push_res;

	logic                accept;

	// Patch datapath
	logic [15:0]         word;
	logic [10:0]         skip;
	logic [4:0]          code;
	logic [TILE_W-1:0]   patch_val;
	logic [POS_W:0]      sum;
	logic [POS_W-1:0]    pos1, pos2, left_dec;
	logic [POS_W-1:0]    count12;
	logic [POS_W-1:0]    idx_ext;
	logic [3:0]          mode, extra;

	assign req.ready = (state_q == ST_IDLE) && (q_cnt_q != 2'd2);
	assign accept    = req.valid && req.ready;

	assign rsp.valid = (q_cnt_q != 2'd0);
	assign rsp.data  = q_data_q[q_rptr_q];
	assign pop       = rsp.valid && rsp.ready;

	assign word      = {high_q, req.data.byte_value};
	assign skip      = word[15:5];
	assign code      = word[4:0];
	assign patch_val = code[4] ? TILE_HIGH : {3'b000, code};
	assign sum       = {1'b0, pos_q} + {2'b00, skip};
	assign pos1      = sum[POS_W] ? POS_MAX : sum[POS_W-1:0];
	assign pos2      = (pos1 == POS_MAX) ? POS_MAX : pos1 + 12'd1;
	assign left_dec  = left_q - 12'd1;
	assign mode      = req.data.byte_value[7:4];
	assign extra     = req.data.byte_value[3:0];
	assign idx_ext   = {2'b00, req.data.tile_index};

	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		left_d      = left_q;
		pos_d       = pos_q;
		high_d      = high_q;
		cnt_hi_d    = cnt_hi_q;
		fill_val_d  = fill_val_q;
		fill_push_d = fill_push_q;
		fill_done_d = fill_done_q;
		rd_oob_d    = rd_oob_q;
		fill_cnt_d  = '0;
		ram_addr    = idx_ext[ADDR_W-1:0];
		ram_we      = 1'b0;
		ram_wdata   = patch_val;
		push        = 1'b0;
		push_res    = '{read_value: 8'h00, frame_done: 1'b0, error_code: ERR_NONE};
		count12     = {4'h0, req.data.byte_value};

		unique case (state_q)
			ST_FILL: begin
				// One entry per cycle
				ram_addr  = fill_cnt_q;
				ram_we    = 1'b1;
				ram_wdata = {4'h0, fill_val_q};
				if (fill_cnt_q == FILL_LAST) begin
					state_d             = ST_IDLE;
					push                = fill_push_q;
					push_res.frame_done = fill_done_q;
				end else begin
					fill_cnt_d = fill_cnt_q + 1'b1;
				end
			end
			ST_READ: begin
				push                = 1'b1;
				push_res.read_value = rd_oob_q ? 8'h00 : ram_rdata;
				state_d             = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (req.data.opcode == OP_READ) begin
						rd_oob_d = (idx_ext >= TILE_LIMIT);
						state_d  = ST_READ;
					end else begin
						push = 1'b1;
						case (phase_q)
							PH_COUNT8, PH_COUNT_LO: begin
								if (phase_q == PH_COUNT_LO) begin
									count12 = {cnt_hi_q, req.data.byte_value};
								end
								left_d = count12;
								pos_d  = '0;
								if (count12 == '0) begin
									push_res.frame_done = 1'b1;
									phase_d             = PH_HEADER;
								end else begin
									phase_d = PH_PATCH_HI;
								end
							end
							PH_PATCH_HI: begin
								high_d  = req.data.byte_value;
								phase_d = PH_PATCH_LO;
							end
							PH_PATCH_LO: begin
								ram_addr = pos1[ADDR_W-1:0];
								if (pos1 < TILE_LIMIT) begin
									ram_we = 1'b1;
								end else begin
									push_res.error_code = ERR_RANGE;
								end
								pos_d  = pos2;
								left_d = left_dec;
								if (left_dec == '0) begin
									push_res.frame_done = 1'b1;
									phase_d             = PH_HEADER;
								end else begin
									phase_d = PH_PATCH_HI;
								end
							end
							default: begin
								// Header byte
								phase_d = PH_HEADER;
								if (mode == MODE_PLAIN || mode == MODE_PLAIN_PIX) begin
									push        = 1'b0;
									state_d     = ST_FILL;
									fill_val_d  = extra;
									fill_push_d = 1'b1;
									fill_done_d = (mode == MODE_PLAIN);
									if (mode == MODE_PLAIN_PIX) begin
										phase_d = PH_COUNT8;
									end
								end else if (mode == MODE_DERIVE) begin
									cnt_hi_d = extra;
									phase_d  = PH_COUNT_LO;
								end else begin
									push_res.error_code = ERR_MODE;
								end
							end
						endcase
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			phase_q     <= PH_HEADER;
			left_q      <= '0;
			pos_q       <= '0;
			high_q      <= '0;
			cnt_hi_q    <= '0;
			fill_cnt_q  <= '0;
			fill_val_q  <= '0;
			fill_push_q <= 1'b0;
			fill_done_q <= 1'b0;
			rd_oob_q    <= 1'b0;
		end else begin
			state_q     <= state_d;
			phase_q     <= phase_d;
			left_q      <= left_d;
			pos_q       <= pos_d;
			high_q      <= high_d;
			cnt_hi_q    <= cnt_hi_d;
			fill_cnt_q  <= fill_cnt_d;
			fill_val_q  <= fill_val_d;
			fill_push_q <= fill_push_d;
			fill_done_q <= fill_done_d;
			rd_oob_q    <= rd_oob_d;
		end
	end

	// Result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wptr_q <= 1'b0;
			q_rptr_q <= 1'b0;
			q_cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				q_wptr_q <= ~q_wptr_q;
			end
			if (pop) begin
				q_rptr_q <= ~q_rptr_q;
			end
			q_cnt_q <= q_cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_data_q[q_wptr_q] <= push_res;
		end
	end

	tfdd_ram #(
		.WIDTH(TILE_W),
		.DEPTH(TILE_COUNT)
	) u_store (
		.clk  (clk),
		.addr (ram_addr),
		.we   (ram_we),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

endmodule

// ===== sv/tfdd_ram.sv =====
module tfdd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic                     we,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== sv/tfdd_checker.sv =====
module tfdd_checker import tfdd_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input out_item_t rsp_data
);

	// A pending result is not withdrawn
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// Nonzero read data only comes from a read, which has no status
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.read_value != 8'h00) |->
		!rsp_data.frame_done && (rsp_data.error_code == ERR_NONE))
		else $error("read result carries stream status");

	// Unused error code never shows
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.error_code != 2'd3))
		else $error("invalid error code");

	// A rejected header never ends a frame
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.error_code == ERR_MODE) |-> !rsp_data.frame_done)
		else $error("frame done on unsupported mode");

endmodule

bind tilemap_frame_delta_decoder tfdd_checker u_tfdd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_data (rsp.data)
);

// ===== test/tb.sv =====
module tb;
	import tfdd_pkg::*;

	// Header modes the decoder does not support; they must come back as a mode error.
	localparam logic [3:0] MODE_SPARE_1   = 4'h1;
	localparam logic [3:0] MODE_SPARE_2   = 4'h2;
	localparam logic [3:0] MODE_SPARE_TOP = 4'hF;

	localparam int HALF_PERIOD = 6;
	localparam int STOP_CYCLES = 600000;  // far beyond the slowest legal run
	localparam int STREAM_GOAL = 700;     // includes one long derive frame
	localparam int BIG_AT      = 100;     // stream length at which the long derive frame goes in
	localparam int CALM_TAIL   = 120;     // last transfers run with no idling
	localparam int BACKLOG_LEN = 1500;    // long sink hold-off, covers a fill sweep too

	typedef struct {
		in_item_t item;
		bit       hold_for_drain;  // sender waits for every result before offering this
	} stream_entry_t;

	logic clk;
	logic arst_n;

	tfdd_in_if  req_if ();
	tfdd_out_if rsp_if ();

	tilemap_frame_delta_decoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Shadow copy of the decoder state, advanced once per accepted transfer.
	logic [TILE_W-1:0] tiles [TILE_COUNT];
	phase_t            phase;
	logic [POS_W-1:0]  patches_due;
	logic [POS_W-1:0]  wr_pos;
	logic [7:0]        word_hi;
	logic [3:0]        count_hi;

	stream_entry_t stream_q [$];   // bytes and reads still to be offered
	out_item_t     decoded_q [$];  // decoder responses still owed, oldest first

	int  stream_total;
	int  items_taken;
	int  bad_count;
	bit  in_taken;   // set at the rising edge when the input transfer happened
	bit  calm;       // tail of the run: no idling on either side
	bit  drain_next;
	bit  mix_reads;
	int  src_gap;
	int  sink_gap;
	int  hold_left;
	bit  hold_fired;

	task automatic flag_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		bad_count++;
	endtask

	// Write position adds saturate at the top of the 12-bit range, never wrap.
	function automatic logic [POS_W-1:0] pos_add(logic [POS_W-1:0] a, int unsigned b);
		int unsigned s;
		s = a + b;
		return (s > POS_MAX) ? POS_MAX : POS_W'(s);
	endfunction

	// Arms a patch run; a zero count closes the frame on the count byte itself.
	function automatic bit open_patches(logic [POS_W-1:0] n);
		patches_due = n;
		wr_pos = '0;
		phase = (n == 0) ? PH_HEADER : PH_PATCH_HI;
		return n == 0;
	endfunction

	function automatic out_item_t decode_item(in_item_t it);
		out_item_t   r;
		logic [15:0] word;
		logic [3:0]  mode;
		r = '0;
		if (it.opcode == OP_READ) begin
			// reads never disturb the parser
			if (it.tile_index < TILE_COUNT)
				r.read_value = tiles[it.tile_index];
		end else begin
			case (phase)
				PH_COUNT8: r.frame_done = open_patches({4'h0, it.byte_value});
				PH_COUNT_LO: r.frame_done = open_patches({count_hi, it.byte_value});
				PH_PATCH_HI: begin
					word_hi = it.byte_value;
					phase = PH_PATCH_LO;
				end
				PH_PATCH_LO: begin
					// big-endian word: 11-bit skip on top, 5-bit code below
					word = {word_hi, it.byte_value};
					wr_pos = pos_add(wr_pos, word[15:5]);
					if (wr_pos < TILE_COUNT)
						tiles[wr_pos] = word[4] ? TILE_HIGH : {3'b000, word[4:0]};
					else
						r.error_code = ERR_RANGE;  // dropped, position still moves on
					wr_pos = pos_add(wr_pos, 1);
					patches_due = patches_due - 1'b1;
					if (patches_due == 0) begin
						r.frame_done = 1'b1;
						phase = PH_HEADER;
					end else begin
						phase = PH_PATCH_HI;
					end
				end
				default: begin
					// header; any unused phase value lands here as well
					mode = it.byte_value[7:4];
					phase = PH_HEADER;
					if (mode == MODE_PLAIN || mode == MODE_PLAIN_PIX) begin
						foreach (tiles[i])
							tiles[i] = {4'h0, it.byte_value[3:0]};
						if (mode == MODE_PLAIN)
							r.frame_done = 1'b1;
						else
							phase = PH_COUNT8;
					end else if (mode == MODE_DERIVE) begin
						count_hi = it.byte_value[3:0];
						phase = PH_COUNT_LO;
					end else begin
						r.error_code = ERR_MODE;
					end
				end
			endcase
		end
		return r;
	endfunction

	// Stimulus builders. The unused field of each item still gets random bits.
	task automatic add_item(input in_item_t it);
		stream_entry_t e;
		e.item = it;
		e.hold_for_drain = drain_next;
		drain_next = 1'b0;
		stream_q.push_back(e);
	endtask

	task automatic add_byte(input logic [7:0] b);
		add_item('{opcode: OP_BYTE, byte_value: b, tile_index: 10'($urandom)});
	endtask

	task automatic add_read(input logic [9:0] idx);
		add_item('{opcode: OP_READ, byte_value: 8'($urandom), tile_index: idx});
	endtask

	task automatic add_patch(input int unsigned skip, input int unsigned code);
		logic [15:0] word;
		word = {11'(skip), 5'(code)};
		add_byte(word[15:8]);
		if (mix_reads && $urandom_range(0, 6) == 0)
			add_read(10'($urandom_range(0, TILE_COUNT - 1)));
		add_byte(word[7:0]);
	endtask

	// Mostly short skips so writes land inside the store; now and then a far one.
	task automatic add_rand_patch();
		int unsigned skip;
		case ($urandom_range(0, 9))
			0: skip = $urandom_range(0, 2047);
			1, 2: skip = $urandom_range(0, 40);
			default: skip = $urandom_range(0, 3);
		endcase
		add_patch(skip, $urandom_range(0, 31));
	endtask

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// Single reset at time zero; every block input starts at a known value.
	initial begin
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		rsp_if.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#(2 * HALF_PERIOD * STOP_CYCLES);
		$display("RESULT: ERROR");
		$finish;
	end

	// Sender: offers the head of stream_q at the falling edge, holds it until transferred.
	always @(negedge clk) begin
		stream_entry_t nxt;
		if (arst_n && (req_if.valid !== 1'b1 || in_taken)) begin
			if (src_gap > 0) begin
				src_gap--;
				req_if.valid <= 1'b0;
			end else if (stream_q.size() > 0
					&& (!stream_q[0].hold_for_drain || decoded_q.size() == 0)) begin
				nxt = stream_q.pop_front();
				req_if.valid <= 1'b1;
				req_if.data <= nxt.item;
				if (!calm && $urandom_range(0, 3) == 0)
					src_gap = $urandom_range(1, 4);
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// Receiver: short random stalls, plus one long hold-off mid-run so the
	// decoder backs up and has to refuse input while the sender keeps offering.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_fired && items_taken >= 300) begin
				hold_fired = 1'b1;
				hold_left = BACKLOG_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
				if (!calm && $urandom_range(0, 4) == 0)
					sink_gap = $urandom_range(1, 4);
			end
		end
	end

	// Monitor: check the output transfer against the oldest owed response, then
	// run the shadow decoder on the input transfer of the same edge.
	always @(posedge clk) begin
		out_item_t want;
		in_taken = arst_n && req_if.valid === 1'b1 && req_if.ready === 1'b1;
		if (arst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			if (decoded_q.size() == 0) begin
				flag_mismatch("response with nothing outstanding");
			end else begin
				want = decoded_q.pop_front();
				if (rsp_if.data.read_value !== want.read_value)
					flag_mismatch($sformatf("read_value %h, want %h",
						rsp_if.data.read_value, want.read_value));
				if (rsp_if.data.frame_done !== want.frame_done)
					flag_mismatch($sformatf("frame_done %b, want %b",
						rsp_if.data.frame_done, want.frame_done));
				if (rsp_if.data.error_code !== want.error_code)
					flag_mismatch($sformatf("error_code %0d, want %0d",
						rsp_if.data.error_code, want.error_code));
			end
		end
		if (in_taken) begin
			decoded_q.push_back(decode_item(req_if.data));
			items_taken++;
			calm = items_taken + CALM_TAIL >= stream_total;
		end
	end

	initial begin
		int unsigned pick;
		int unsigned n;
		int unsigned k;
		int          next_drain;
		bit          big_done;

		foreach (tiles[i])
			tiles[i] = '0;
		phase = PH_HEADER;
		patches_due = '0;
		wr_pos = '0;
		word_hi = '0;
		count_hi = '0;
		items_taken = 0;
		bad_count = 0;
		in_taken = 1'b0;
		calm = 1'b0;
		src_gap = 0;
		sink_gap = 0;
		hold_left = 0;
		hold_fired = 1'b0;
		drain_next = 1'b0;
		mix_reads = 1'b0;

		// --- directed part ---
		add_read(10'd0);                      // store is clear out of reset
		add_read(10'(TILE_COUNT - 1));
		add_byte({MODE_PLAIN, 4'h5});         // plain fill
		add_read(10'(TILE_COUNT - 1));
		add_byte({MODE_SPARE_1, 4'h0});       // unsupported modes
		add_byte({MODE_SPARE_2, 4'hF});
		add_byte({MODE_SPARE_TOP, 4'h0});
		add_byte({MODE_PLAIN_PIX, 4'hA});     // fill, then zero count ends the frame
		add_byte(8'h00);
		add_byte({MODE_PLAIN_PIX, 4'hF});
		add_byte(8'd3);
		add_patch(0, 5'h1F);                  // code with bit 4 set stores 0x80
		add_patch(0, 5'h0F);                  // plain code stores itself
		add_patch(2047, 5'h00);               // far past the store: dropped, frame ends
		add_byte({MODE_DERIVE, 4'h0});
		add_byte(8'd3);
		add_patch(0, 5'h10);
		add_patch(2047, 5'h05);
		add_patch(2047, 5'h00);               // position pins at its ceiling
		add_read(10'd0);
		add_read(10'd1);
		add_byte({MODE_DERIVE, 4'h0});        // derive with zero count
		add_byte(8'h00);

		// --- random part: mostly whole frames, some bad headers and torn frames ---
		mix_reads = 1'b1;
		drain_next = 1'b1;
		next_drain = stream_q.size() + 200;
		big_done = 1'b0;
		while (stream_q.size() < STREAM_GOAL) begin
			if (stream_q.size() >= next_drain) begin
				drain_next = 1'b1;
				next_drain += 200;
			end
			if (!big_done && stream_q.size() >= BIG_AT) begin
				// derive count above 255: uses the header nibble as count high bits
				big_done = 1'b1;
				n = 256 + $urandom_range(0, 15);
				add_byte({MODE_DERIVE, 4'h1});
				add_byte(8'(n));
				repeat (n) add_rand_patch();
			end
			pick = $urandom_range(0, 19);
			if (pick < 2) begin
				add_byte({MODE_PLAIN, 4'($urandom)});
			end else if (pick < 8) begin
				n = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
				add_byte({MODE_PLAIN_PIX, 4'($urandom)});
				add_byte(8'(n));
				repeat (n) add_rand_patch();
			end else if (pick < 15) begin
				n = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
				add_byte({MODE_DERIVE, 4'h0});
				add_byte(8'(n));
				repeat (n) add_rand_patch();
			end else if (pick < 17) begin
				do
					k = $urandom_range(0, 15);
				while (k == MODE_PLAIN || k == MODE_PLAIN_PIX || k == MODE_DERIVE);
				add_byte({4'(k), 4'($urandom)});
			end else begin
				// torn frame: stops inside a patch, later bytes get eaten as patches
				n = $urandom_range(2, 6);
				add_byte({MODE_PLAIN_PIX, 4'($urandom)});
				add_byte(8'(n));
				repeat ($urandom_range(0, n - 1)) add_rand_patch();
				add_byte(8'($urandom));
			end
			repeat ($urandom_range(0, 2))
				add_read(10'($urandom_range(0, TILE_COUNT - 1)));
		end
		stream_total = stream_q.size();

		// wait for the stream to drain and every response to come back
		@(posedge clk);
		while (stream_q.size() > 0 || req_if.valid === 1'b1 || decoded_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);  // catch any stray trailing response
		if (bad_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
